@@ rtl/core/mlfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfs_pkg
// Shared constants, byte codes and controller/datapath bundles for the
// meter line field splitter.
// ----------------------------------------------------------------------------
package mlfs_pkg;

   localparam int LINE_DEPTH = 30;
   localparam int IDX_W      = $clog2(LINE_DEPTH);
   localparam int BYTE_W     = 8;
   localparam int TEXT_CHARS = 8;
   localparam int TEXT_W     = TEXT_CHARS * BYTE_W;
   localparam int POS_W      = $clog2(TEXT_CHARS);
   localparam int LEN_W      = 5;
   localparam int NUM_W      = 31;
   localparam int MAG_W      = 30;
   localparam int WIDE_W     = MAG_W + 4;

   localparam logic [BYTE_W-1:0] BYTE_LF    = 8'd10;
   localparam logic [BYTE_W-1:0] BYTE_VT    = 8'd11;
   localparam logic [BYTE_W-1:0] BYTE_FF    = 8'd12;
   localparam logic [BYTE_W-1:0] BYTE_CR    = 8'd13;
   localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] BYTE_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] BYTE_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] BYTE_NINE  = 8'h39;

   localparam logic [MAG_W-1:0] NUM_LIMIT = 30'd999999999;

   typedef struct packed {
      logic             accept;
      logic             start;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             proc;
      logic             load;
   } mlfs_cmd_type;

   typedef struct packed {
      logic             close_hit;
      logic [IDX_W-1:0] line_len;
   } mlfs_sts_type;

endpackage

@@ rtl/core/mlfs_if.sv @@
// ----------------------------------------------------------------------------
// mlfs_if
// Valid/ready channels for received bytes and for parsed line results.
// ----------------------------------------------------------------------------
interface mlfs_req_if
   import mlfs_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlfs_rsp_if
   import mlfs_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [TEXT_W-1:0]       code_text;
   logic [LEN_W-1:0]        code_length;
   logic [TEXT_W-1:0]       value_text;
   logic [LEN_W-1:0]        value_length;
   logic signed [NUM_W-1:0] value_number;

   modport source (output valid, output code_text, output code_length,
                   output value_text, output value_length, output value_number,
                   input ready);
   modport sink   (input valid, input code_text, input code_length,
                   input value_text, input value_length, input value_number,
                   output ready);
endinterface

@@ rtl/core/mlfs_ram.sv @@
// ----------------------------------------------------------------------------
// mlfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mlfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlfs_ctrl
// Controller: takes bytes, sequences the buffer walk and the result load,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module mlfs_ctrl
   import mlfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  mlfs_sts_type sts,
   output mlfs_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             proc_ff, proc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      proc_in     = 1'b0;
      cmd         = '0;
      cmd.accept  = req_valid && req_ready;
      cmd.rd_addr = cnt_ff;
      cmd.proc    = proc_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept && sts.close_hit) begin
               cmd.start = 1'b1;
               cnt_in    = '0;
               state_in  = S_WALK;
            end
         end
         S_WALK: begin
            if (cnt_ff != sts.line_len) begin
               cmd.rd_en = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
               proc_in   = 1'b1;
            end else if (!proc_ff) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         proc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         proc_ff      <= proc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/mlfs_dp.sv @@
// ----------------------------------------------------------------------------
// mlfs_dp
// Datapath: line buffer, write index, field splitter, number reader and
// result register.
// ----------------------------------------------------------------------------
module mlfs_dp
   import mlfs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mlfs_cmd_type            cmd,
   output mlfs_sts_type            sts,
   input  logic [BYTE_W-1:0]       rx_byte,
   output logic [TEXT_W-1:0]       code_text,
   output logic [LEN_W-1:0]        code_length,
   output logic [TEXT_W-1:0]       value_text,
   output logic [LEN_W-1:0]        value_length,
   output logic signed [NUM_W-1:0] value_number
);

   localparam logic [1:0] N_SKIP  = 2'd0;
   localparam logic [1:0] N_DIGIT = 2'd1;
   localparam logic [1:0] N_DONE  = 2'd2;

   logic [IDX_W-1:0]  widx_ff, widx_in;
   logic              open_ff, open_in;
   logic              wr_en;
   logic [BYTE_W-1:0] ch;

   logic [1:0]        spaces_ff, spaces_in;
   logic [TEXT_W-1:0] ctext_ff, ctext_in;
   logic [TEXT_W-1:0] vtext_ff, vtext_in;
   logic [LEN_W-1:0]  clen_ff, clen_in;
   logic [LEN_W-1:0]  vlen_ff, vlen_in;
   logic [1:0]        nstate_ff, nstate_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [3:0]        digit;
   logic [WIDE_W-1:0] wide;
   logic              is_digit;

   logic [TEXT_W-1:0]       out_ctext_ff;
   logic [LEN_W-1:0]        out_clen_ff;
   logic [TEXT_W-1:0]       out_vtext_ff;
   logic [LEN_W-1:0]        out_vlen_ff;
   logic signed [NUM_W-1:0] out_num_ff, out_num_in;

   assign sts.close_hit = (rx_byte == BYTE_CR) && open_ff;
   assign sts.line_len  = widx_ff;

   always_comb begin
      widx_in = widx_ff;
      open_in = open_ff;
      wr_en   = 1'b0;
      if (cmd.accept) begin
         if (rx_byte == BYTE_LF) begin
            open_in = 1'b1;
            widx_in = '0;
         end else if (rx_byte == BYTE_CR) begin
            open_in = 1'b0;
         end else if (rx_byte > BYTE_LF) begin
            wr_en = 1'b1;
            if (widx_ff == IDX_W'(LINE_DEPTH - 1)) begin
               widx_in = '0;
            end else begin
               widx_in = widx_ff + 1'b1;
            end
         end
      end
   end

   mlfs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (widx_ff),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (ch)
   );

   assign is_digit = (ch inside {[BYTE_ZERO:BYTE_NINE]});
   assign digit    = 4'(ch - BYTE_ZERO);
   assign wide     = (WIDE_W'(mag_ff) << 3) + (WIDE_W'(mag_ff) << 1) + WIDE_W'(digit);

   always_comb begin
      spaces_in = spaces_ff;
      ctext_in  = ctext_ff;
      vtext_in  = vtext_ff;
      clen_in   = clen_ff;
      vlen_in   = vlen_ff;
      nstate_in = nstate_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      if (cmd.start) begin
         spaces_in = '0;
         ctext_in  = '0;
         vtext_in  = '0;
         clen_in   = '0;
         vlen_in   = '0;
         nstate_in = N_SKIP;
         neg_in    = 1'b0;
         mag_in    = '0;
      end else if (cmd.proc) begin
         if (ch == BYTE_SPACE) begin
            if (spaces_ff != 2'd2) begin
               spaces_in = spaces_ff + 1'b1;
            end
         end else if (spaces_ff == 2'd0) begin
            if (clen_ff < LEN_W'(TEXT_CHARS)) begin
               ctext_in[BYTE_W*POS_W'(clen_ff) +: BYTE_W] = ch;
            end
            clen_in = clen_ff + 1'b1;
         end else if (spaces_ff == 2'd1) begin
            if (vlen_ff < LEN_W'(TEXT_CHARS)) begin
               vtext_in[BYTE_W*POS_W'(vlen_ff) +: BYTE_W] = ch;
            end
            vlen_in = vlen_ff + 1'b1;
            case (nstate_ff)
               N_SKIP: begin
                  if (ch == BYTE_VT || ch == BYTE_FF) begin
                     nstate_in = N_SKIP;
                  end else if (ch == BYTE_PLUS || ch == BYTE_MINUS) begin
                     neg_in    = (ch == BYTE_MINUS);
                     nstate_in = N_DIGIT;
                  end else if (is_digit) begin
                     mag_in    = MAG_W'(wide);
                     nstate_in = N_DIGIT;
                  end else begin
                     nstate_in = N_DONE;
                  end
               end
               N_DIGIT: begin
                  if (is_digit) begin
                     if (wide > WIDE_W'(NUM_LIMIT)) begin
                        mag_in = NUM_LIMIT;
                     end else begin
                        mag_in = MAG_W'(wide);
                     end
                  end else begin
                     nstate_in = N_DONE;
                  end
               end
               N_DONE: begin
                  nstate_in = N_DONE;
               end
               default: begin
                  nstate_in = N_DONE;
               end
            endcase
         end
      end
   end

   always_comb begin
      if (neg_ff) begin
         out_num_in = NUM_W'(0) - NUM_W'(mag_ff);
      end else begin
         out_num_in = NUM_W'(mag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         widx_ff <= widx_in;
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      spaces_ff <= spaces_in;
      ctext_ff  <= ctext_in;
      vtext_ff  <= vtext_in;
      clen_ff   <= clen_in;
      vlen_ff   <= vlen_in;
      nstate_ff <= nstate_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      if (cmd.load) begin
         out_ctext_ff <= ctext_ff;
         out_clen_ff  <= clen_ff;
         out_vtext_ff <= vtext_ff;
         out_vlen_ff  <= vlen_ff;
         out_num_ff   <= out_num_in;
      end
   end

   assign code_text    = out_ctext_ff;
   assign code_length  = out_clen_ff;
   assign value_text   = out_vtext_ff;
   assign value_length = out_vlen_ff;
   assign value_number = out_num_ff;

endmodule

@@ rtl/core/meter_line_field_splitter.sv @@
// A closing carriage return gives a valid result after a one-entry-per-cycle walk
// over the line buffer read port.
// Throughput: one byte per cycle while idle; input held off for the walk plus any
// wait for a pending result to drain.
// Reset clears write index, open-line flag and result valid; buffer undefined.
// ----------------------------------------------------------------------------
// meter_line_field_splitter
// Splits carriage-return terminated lines into code and value fields and
// reads the value as a saturated decimal number.
// ----------------------------------------------------------------------------
module meter_line_field_splitter
   import mlfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mlfs_req_if.sink   req_chan,
   mlfs_rsp_if.source rsp_chan
);

   mlfs_cmd_type cmd;
   mlfs_sts_type sts;

   mlfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mlfs_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .rx_byte      (req_chan.rx_byte),
      .code_text    (rsp_chan.code_text),
      .code_length  (rsp_chan.code_length),
      .value_text   (rsp_chan.value_text),
      .value_length (rsp_chan.value_length),
      .value_number (rsp_chan.value_number)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register loaded while a result is pending");

   a_walk_in_line: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (cmd.rd_addr < sts.line_len))
      else $error("walk read beyond the written line");

   a_close_blocks: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && sts.close_hit) |=> !req_chan.ready)
      else $error("input taken during a line walk");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      sts.line_len < IDX_W'(LINE_DEPTH))
      else $error("write index out of range");

endmodule

@@ test/meter_line_field_splitter_tb.sv @@
// ----------------------------------------------------------------------------
// meter_line_field_splitter_tb
// Drives received bytes into the meter line field splitter and checks every
// parsed line result against a shadow tokenizer that tracks the line buffer,
// write index and open-line flag. Directed lines cover control bytes, stray
// carriage returns, empty and space-heavy lines and number forms. Random
// well-formed lines with noise follow under four handshake pacing phases.
// ----------------------------------------------------------------------------
module meter_line_field_splitter_tb;
   import mlfs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 450;

   typedef struct packed {
      logic [TEXT_W-1:0] code_text;
      logic [LEN_W-1:0]  code_length;
      logic [TEXT_W-1:0] value_text;
      logic [LEN_W-1:0]  value_length;
      logic [NUM_W-1:0]  value_number;
   } line_fields_type;

   logic clock = 1'b0;
   logic reset;

   mlfs_req_if req_bus ();
   mlfs_rsp_if rsp_bus ();

   meter_line_field_splitter u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #6 clock = ~clock;

   logic [BYTE_W-1:0] shadow_buf [LINE_DEPTH];
   int unsigned       shadow_idx;
   bit                shadow_open;

   line_fields_type pending_lines [$];

   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned content_items;
   int unsigned control_items;
   int unsigned lines_checked;
   int unsigned mismatches;
   int unsigned cycle_count;

   function automatic line_fields_type split_line();
      line_fields_type   res;
      logic [BYTE_W-1:0] val [LINE_DEPTH];
      logic [BYTE_W-1:0] ch;
      int unsigned       spaces, clen, vlen, k, mag, d, lim;
      bit                neg;
      logic [NUM_W-1:0]  num;
      res    = '0;
      spaces = 0;
      clen   = 0;
      vlen   = 0;
      for (int i = 0; i < shadow_idx; i++) begin
         ch = shadow_buf[IDX_W'(i)];
         if (ch == BYTE_SPACE) begin
            if (spaces < 2) spaces++;
         end else if (spaces == 0) begin
            if (clen < TEXT_CHARS) res.code_text[8*clen +: 8] = ch;
            clen++;
         end else if (spaces == 1) begin
            if (vlen < TEXT_CHARS) res.value_text[8*vlen +: 8] = ch;
            val[IDX_W'(vlen)] = ch;
            vlen++;
         end
      end
      res.code_length  = clen[LEN_W-1:0];
      res.value_length = vlen[LEN_W-1:0];
      lim = 32'(NUM_LIMIT);
      mag = 0;
      neg = 1'b0;
      k   = 0;
      while (k < vlen && (val[IDX_W'(k)] == BYTE_VT || val[IDX_W'(k)] == BYTE_FF)) k++;
      if (k < vlen && (val[IDX_W'(k)] == BYTE_PLUS || val[IDX_W'(k)] == BYTE_MINUS)) begin
         neg = (val[IDX_W'(k)] == BYTE_MINUS);
         k++;
      end
      while (k < vlen && val[IDX_W'(k)] >= BYTE_ZERO && val[IDX_W'(k)] <= BYTE_NINE) begin
         d = 32'(val[IDX_W'(k)] - BYTE_ZERO);
         if (mag > (lim - d) / 10) mag = lim;
         else mag = mag * 10 + d;
         k++;
      end
      num = mag[NUM_W-1:0];
      if (neg) num = -num;
      res.value_number = num;
      return res;
   endfunction

   function automatic bit absorb_byte(input logic [BYTE_W-1:0] b,
                                      output line_fields_type res);
      res = '0;
      if (b < BYTE_LF) return 1'b0;
      if (b == BYTE_LF) begin
         shadow_open = 1'b1;
         shadow_idx  = 0;
         return 1'b0;
      end
      if (b == BYTE_CR) begin
         if (!shadow_open) return 1'b0;
         shadow_open = 1'b0;
         res = split_line();
         return 1'b1;
      end
      shadow_buf[IDX_W'(shadow_idx)] = b;
      shadow_idx = (shadow_idx + 1) % LINE_DEPTH;
      return 1'b0;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      line_fields_type fields;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      if (absorb_byte(b, fields)) pending_lines.push_back(fields);
      if (b < BYTE_LF) control_items++;
      else content_items++;
   endtask

   task automatic wait_lines_done();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_lines.size() != 0);
   endtask

   task automatic set_pacing(input int unsigned idle_pct, input int unsigned stall_pct);
      wait_lines_done();
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
   endtask

   function automatic logic [BYTE_W-1:0] random_text_char();
      int unsigned       r;
      logic [BYTE_W-1:0] c;
      r = $urandom_range(99);
      if (r < 35) return 8'(8'h41 + $urandom_range(25));
      if (r < 60) return 8'(BYTE_ZERO + $urandom_range(9));
      do c = 8'($urandom_range(11, 255)); while (c == BYTE_CR || c == BYTE_SPACE);
      return c;
   endfunction

   task automatic send_content(input logic [BYTE_W-1:0] b);
      if ($urandom_range(99) < 4) send_byte(8'($urandom_range(9)));
      send_byte(b);
   endtask

   task automatic send_random_line();
      int unsigned shape, ending;
      shape = $urandom_range(99);
      if (shape < 8) begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
         return;
      end
      send_byte(BYTE_LF);
      if (shape < 16) begin
         repeat ($urandom_range(28, 45)) begin
            if ($urandom_range(9) == 0) send_content(BYTE_SPACE);
            else send_content(random_text_char());
         end
      end else begin
         repeat ($urandom_range(0, 10)) send_content(random_text_char());
         if ($urandom_range(9) != 0) send_content(BYTE_SPACE);
         if ($urandom_range(9) < 2)
            repeat ($urandom_range(1, 2)) send_content($urandom_range(0, 1) ? BYTE_VT : BYTE_FF);
         case ($urandom_range(3))
            0: send_content(BYTE_MINUS);
            1: send_content(BYTE_PLUS);
            default: ;
         endcase
         repeat ($urandom_range(0, 12)) send_content(8'(BYTE_ZERO + $urandom_range(9)));
         repeat ($urandom_range(0, 3)) send_content(random_text_char());
         if ($urandom_range(3) == 0) begin
            send_content(BYTE_SPACE);
            repeat ($urandom_range(0, 4)) send_content(random_text_char());
         end
         if ($urandom_range(19) == 0) begin
            send_content(BYTE_LF);
            repeat ($urandom_range(0, 4)) send_content(random_text_char());
         end
      end
      ending = $urandom_range(19);
      if (ending != 0) send_byte(BYTE_CR);
      if (ending == 1) send_byte(BYTE_CR);
   endtask

   task automatic test_control_and_stray();
      send_byte(8'h00);
      send_byte(8'h09);
      send_byte(BYTE_CR);
      send_byte("Z");
   endtask

   task automatic test_line_spacing();
      send_byte(BYTE_LF);
      send_byte(BYTE_CR);
      send_byte(BYTE_LF);
      send_byte("A");
      send_byte(BYTE_SPACE);
      send_byte(BYTE_SPACE);
      send_byte("B");
      send_byte(BYTE_CR);
   endtask

   task automatic test_number_forms();
      send_byte(BYTE_LF);
      send_byte(8'hFF);
      send_byte(BYTE_SPACE);
      send_byte(BYTE_VT);
      send_byte(BYTE_FF);
      send_byte(BYTE_MINUS);
      send_byte(BYTE_NINE);
      send_byte(BYTE_NINE);
      send_byte(BYTE_SPACE);
      send_byte("x");
      send_byte(BYTE_CR);
   endtask

   task automatic test_random_lines(input int unsigned goal);
      int unsigned start;
      start = content_items;
      while (content_items - start < goal) begin
         send_random_line();
         if ($urandom_range(99) < 3) wait_lines_done();
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      line_fields_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_lines.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected line result: expected none, actual code %h value %h",
                     $time, rsp_bus.code_text, rsp_bus.value_text);
         end else begin
            want = pending_lines.pop_front();
            lines_checked++;
            check_field("code_text", want.code_text, rsp_bus.code_text);
            check_field("code_length", want.code_length, rsp_bus.code_length);
            check_field("value_text", want.value_text, rsp_bus.value_text);
            check_field("value_length", want.value_length, rsp_bus.value_length);
            check_field("value_number", want.value_number, $unsigned(rsp_bus.value_number));
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d lines outstanding",
                  cycle_count, pending_lines.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready   = 1'b0;
      shadow_idx      = 0;
      shadow_open     = 1'b0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      content_items   = 0;
      control_items   = 0;
      lines_checked   = 0;
      mismatches      = 0;
      cycle_count     = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_control_and_stray();
      test_line_spacing();
      test_number_forms();

      set_pacing(0, 0);
      test_random_lines(PHASE_ITEMS);
      set_pacing(53, 0);
      test_random_lines(PHASE_ITEMS);
      set_pacing(0, 53);
      test_random_lines(PHASE_ITEMS);
      set_pacing(14, 14);
      test_random_lines(PHASE_ITEMS);

      wait_lines_done();
      repeat (40) @(posedge clock);

      $display("Sent %0d line bytes and %0d control bytes; %0d parsed lines compared",
               content_items, control_items, lines_checked);
      $display("Pacing covered free flow, sender gaps, result stalls and both mixed");
      if (mismatches == 0 && pending_lines.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/mlfs_pkg.sv
rtl/core/mlfs_if.sv
rtl/core/mlfs_ram.sv
rtl/core/mlfs_ctrl.sv
rtl/core/mlfs_dp.sv
rtl/core/meter_line_field_splitter.sv
test/meter_line_field_splitter_tb.sv
